>>> hdl/usls_pkg.sv
package usls_pkg;

    // Request command codes.
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REQUEUE  = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_DEQUEUE  = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_EMPTY      = 2'd1,
        STATUS_DUPLICATE  = 2'd2,
        STATUS_NOT_QUEUED = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } t_state;

    // Fixed payload widths.
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 8;
    localparam int URGENCY_W = 3;
    localparam int STATUS_W  = 2;

endpackage

>>> hdl/usls_req_if.sv
interface usls_req_if;
    import usls_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [SLOT_W-1:0]    stream_slot;
    logic [URGENCY_W-1:0] urgency;
    logic                 incremental;

    modport source (
        output valid, command, stream_slot, urgency, incremental,
        input  ready
    );

    modport sink (
        input  valid, command, stream_slot, urgency, incremental,
        output ready
    );

endinterface

>>> hdl/usls_rsp_if.sv
interface usls_rsp_if;
    import usls_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   served_slot;

    modport source (
        output valid, status, served_slot,
        input  ready
    );

    modport sink (
        input  valid, status, served_slot,
        output ready
    );

endinterface

>>> hdl/urgency_level_stream_scheduler.sv
// Strict-priority scheduler of stream slots over per-urgency doubly linked queues.
// Each request (add, requeue, remove, dequeue) is accepted in the idle state, where
// the link and entry memories are read, and then finishes in the execute state, where
// the result is formed and the memories, heads and tails are written back. No new
// request is accepted until the previous one has finished executing; this follows
// from the read-then-write turn of the synchronous link memories.
// The result sits in an output register, so the next request is accepted while the
// previous result still waits; a request finishes only once that register is free.
// After reset the block first sweeps the entry memory to clear every queued flag, one
// entry per cycle, and accepts no request until the sweep is done.
module urgency_level_stream_scheduler #(
    parameter int STREAM_SLOTS   = 256,
    parameter int URGENCY_LEVELS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    usls_req_if.sink  i_req,
    usls_rsp_if.source o_rsp
);
    import usls_pkg::*;

    localparam int SW = $clog2(STREAM_SLOTS);
    localparam int LW = $clog2(URGENCY_LEVELS);

    // Control state.
    t_state r_state, n_state;
    logic [SW-1:0] r_clr_idx;
    logic          w_fire;
    logic          w_accept;

    // Request held across the execute cycle.
    t_cmd          r_cmd;
    logic [SW-1:0] r_tgt;
    logic          r_in_range;
    logic [LW-1:0] r_urg;
    logic          r_at_head;
    logic          r_any;

    // Per-level queue state.
    logic [URGENCY_LEVELS-1:0] r_nonempty, n_nonempty;
    logic [SW-1:0]             r_head [URGENCY_LEVELS];
    logic [SW-1:0]             r_tail [URGENCY_LEVELS];

    // Output register.
    logic          r_rsp_valid;
    t_status       r_status, n_status;
    logic [SLOT_W-1:0] r_served, n_served;

    // Memory read data: entry metadata is {queued, level}.
    logic [SW-1:0] q_next, q_prev;
    logic [LW:0]   q_meta;

    // Combinational helpers.
    logic [LW-1:0] w_first_lvl, w_exec_lvl, w_lvl_rd;
    logic          w_any;
    logic [SW-1:0] w_head_rd, w_tail_rd, w_tgt_in;
    logic          w_is_insert, w_queued, w_is_head, w_is_tail;
    logic          w_do_link, w_do_unlink;

    // Write port controls.
    logic          nx_we, pv_we, md_we, hd_we, tl_we;
    logic [SW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, hd_wd, tl_wd;
    logic [LW:0]   md_wd;
    logic          w_md_we;
    logic [SW-1:0] w_md_wa;
    logic [LW:0]   w_md_wd;

    // Lowest-numbered nonempty level for dequeue.
    always_comb begin
        w_first_lvl = '0;
        for (int i = URGENCY_LEVELS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                w_first_lvl = LW'(i);
            end
        end
    end
    assign w_any = |r_nonempty;

    // Inserts work on the request's level; removals on the level stored with the entry.
    assign w_is_insert = (r_cmd == CMD_ADD) || (r_cmd == CMD_REQUEUE);
    assign w_exec_lvl  = w_is_insert ? r_urg : q_meta[LW-1:0];

    // Head and tail tables have a single read address: the dequeue level while idle,
    // the working level while executing.
    assign w_lvl_rd  = (r_state == ST_EXEC) ? w_exec_lvl : w_first_lvl;
    assign w_head_rd = r_head[w_lvl_rd];
    assign w_tail_rd = r_tail[w_lvl_rd];

    // A dequeue targets the current head; everything else targets the request's slot.
    assign w_tgt_in = (t_cmd'(i_req.command) == CMD_DEQUEUE) ? w_head_rd
                                                             : SW'(i_req.stream_slot);

    // State machine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        w_fire      = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == SW'(STREAM_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                w_fire = !r_rsp_valid || o_rsp.ready;
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_accept = i_req.valid && i_req.ready;

    // Capture the request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= t_cmd'(i_req.command);
            r_tgt      <= w_tgt_in;
            r_in_range <= (32'(i_req.stream_slot) < STREAM_SLOTS);
            r_urg      <= (32'(i_req.urgency) >= URGENCY_LEVELS) ? LW'(URGENCY_LEVELS - 1)
                                                                 : LW'(i_req.urgency);
            r_at_head  <= (t_cmd'(i_req.command) == CMD_REQUEUE) && !i_req.incremental;
            r_any      <= w_any;
        end
    end

    // Execute: decide the outcome and the write-backs from the read data.
    assign w_queued  = q_meta[LW];
    assign w_is_head = (w_head_rd == r_tgt);
    assign w_is_tail = (w_tail_rd == r_tgt);

    always_comb begin
        n_status    = STATUS_DONE;
        n_served    = '0;
        n_nonempty  = r_nonempty;
        w_do_link   = 1'b0;
        w_do_unlink = 1'b0;
        nx_we = 1'b0;  nx_wa = q_prev;  nx_wd = q_next;
        pv_we = 1'b0;  pv_wa = q_next;  pv_wd = q_prev;
        md_we = 1'b0;  md_wd = {1'b0, w_exec_lvl};
        hd_we = 1'b0;  hd_wd = q_next;
        tl_we = 1'b0;  tl_wd = q_prev;

        case (r_cmd)
            CMD_DEQUEUE: begin
                if (!r_any) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    w_do_unlink = 1'b1;
                    n_served    = SLOT_W'(r_tgt);
                end
            end
            CMD_REMOVE: begin
                if (!r_in_range || !w_queued) begin
                    n_status = STATUS_NOT_QUEUED;
                end else begin
                    w_do_unlink = 1'b1;
                end
            end
            default: begin
                if (!r_in_range) begin
                    n_status = STATUS_NOT_QUEUED;
                end else if (w_queued) begin
                    n_status = STATUS_DUPLICATE;
                end else begin
                    w_do_link = 1'b1;
                end
            end
        endcase

        if (w_do_unlink) begin
            md_we = 1'b1;
            md_wd = {1'b0, w_exec_lvl};
            if (w_is_head && w_is_tail) begin
                n_nonempty[w_exec_lvl] = 1'b0;
            end else if (w_is_head) begin
                hd_we = 1'b1;
                hd_wd = q_next;
            end else if (w_is_tail) begin
                tl_we = 1'b1;
                tl_wd = q_prev;
            end else begin
                // Middle of the queue: join the neighbors to each other.
                nx_we = 1'b1;  nx_wa = q_prev;  nx_wd = q_next;
                pv_we = 1'b1;  pv_wa = q_next;  pv_wd = q_prev;
            end
        end

        if (w_do_link) begin
            md_we = 1'b1;
            md_wd = {1'b1, w_exec_lvl};
            if (!r_nonempty[w_exec_lvl]) begin
                hd_we = 1'b1;  hd_wd = r_tgt;
                tl_we = 1'b1;  tl_wd = r_tgt;
                n_nonempty[w_exec_lvl] = 1'b1;
            end else if (r_at_head) begin
                nx_we = 1'b1;  nx_wa = r_tgt;      nx_wd = w_head_rd;
                pv_we = 1'b1;  pv_wa = w_head_rd;  pv_wd = r_tgt;
                hd_we = 1'b1;  hd_wd = r_tgt;
            end else begin
                pv_we = 1'b1;  pv_wa = r_tgt;      pv_wd = w_tail_rd;
                nx_we = 1'b1;  nx_wa = w_tail_rd;  nx_wd = r_tgt;
                tl_we = 1'b1;  tl_wd = r_tgt;
            end
        end
    end

    // Per-level state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
        end else if (w_fire) begin
            r_nonempty <= n_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && hd_we) begin
            r_head[w_exec_lvl] <= hd_wd;
        end
        if (w_fire && tl_we) begin
            r_tail[w_exec_lvl] <= tl_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_fire) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= n_status;
            r_served <= n_served;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.served_slot = r_served;

    // The entry memory is swept clear after reset, then written only by requests.
    assign w_md_we = (r_state == ST_CLEAR) || (w_fire && md_we);
    assign w_md_wa = (r_state == ST_CLEAR) ? r_clr_idx : r_tgt;
    assign w_md_wd = (r_state == ST_CLEAR) ? '0 : md_wd;

    usls_ram #(.DEPTH(STREAM_SLOTS), .WIDTH(SW)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire && nx_we),
        .i_waddr (nx_wa),
        .i_wdata (nx_wd),
        .i_re    (w_accept),
        .i_raddr (w_tgt_in),
        .o_rdata (q_next)
    );

    usls_ram #(.DEPTH(STREAM_SLOTS), .WIDTH(SW)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire && pv_we),
        .i_waddr (pv_wa),
        .i_wdata (pv_wd),
        .i_re    (w_accept),
        .i_raddr (w_tgt_in),
        .o_rdata (q_prev)
    );

    usls_ram #(.DEPTH(STREAM_SLOTS), .WIDTH(LW + 1)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_md_we),
        .i_waddr (w_md_wa),
        .i_wdata (w_md_wd),
        .i_re    (w_accept),
        .i_raddr (w_tgt_in),
        .o_rdata (q_meta)
    );

`ifndef SYNTH
    // An accepted request always moves on to the execute cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter execute");

    // A new result appears only as an execute cycle completes.
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == ST_EXEC))
        else $error("result raised outside execute");

    // Only a successful dequeue reports a served slot.
    a_served_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != STATUS_DONE)) |-> (o_rsp.served_slot == '0))
        else $error("served slot set on a failed request");

    // Level occupancy changes only while a request executes.
    a_nonempty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EXEC) |=> $stable(r_nonempty))
        else $error("level occupancy changed outside execute");
`endif

endmodule

>>> hdl/usls_ram.sv
// Simple dual-port memory: one write port, one read port with registered data.
module usls_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
